// ===== rtl/core/utf8d_pkg.sv =====
// shared types, register indexes, constants and decode functions of the utf-8 sequence decoder
package utf8d_pkg;

  localparam int unsigned NumBytes  = 6;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 3;
  localparam int unsigned CpW       = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic [CfgIdxW-1:0] {
    IDX_REJ_LO_MIN = 3'd0,
    IDX_REJ_LO_MAX = 3'd1,
    IDX_REJ_HI_MIN = 3'd2,
    IDX_REJ_HI_MAX = 3'd3,
    IDX_ERR_CP     = 3'd4
  } cfg_idx_e;

  localparam logic [ByteW-1:0] RejLoMinRst = 8'h80;
  localparam logic [ByteW-1:0] RejLoMaxRst = 8'hC1;
  localparam logic [ByteW-1:0] RejHiMinRst = 8'hF5;
  localparam logic [ByteW-1:0] RejHiMaxRst = 8'hFF;
  localparam logic [CpW-1:0]   ErrCpRst    = 32'h0000_FFFD;

  typedef struct packed {
    logic [ByteW-1:0] rej_lo_min;
    logic [ByteW-1:0] rej_lo_max;
    logic [ByteW-1:0] rej_hi_min;
    logic [ByteW-1:0] rej_hi_max;
    logic [CpW-1:0]   err_cp;
  } cfg_t;

  typedef logic [NumBytes-1:0][ByteW-1:0] window_t;

  // trailing byte count from the leader
  function automatic logic [LenW-1:0] trail_count(input logic [ByteW-1:0] lead);
    logic [LenW-1:0] t;
    if (lead < 8'hC0)      t = 3'd0;
    else if (lead < 8'hE0) t = 3'd1;
    else if (lead < 8'hF0) t = 3'd2;
    else if (lead < 8'hF8) t = 3'd3;
    else if (lead < 8'hFC) t = 3'd4;
    else                   t = 3'd5;
    return t;
  endfunction

  // marker bits of leader and continuation bytes folded into one constant
  function automatic logic [CpW-1:0] len_offset(input logic [LenW-1:0] trail);
    logic [CpW-1:0] off;
    case (trail)
      3'd1:    off = 32'h0000_3080;
      3'd2:    off = 32'h000E_2080;
      3'd3:    off = 32'h03C8_2080;
      3'd4:    off = 32'hFA08_2080;
      3'd5:    off = 32'h8208_2080;
      default: off = 32'h0000_0000;
    endcase
    return off;
  endfunction

endpackage

// ===== rtl/core/utf8d_cfg.sv =====
// configuration registers: rejected leader ranges and error codepoint
module utf8d_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [utf8d_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [utf8d_pkg::CfgDataW-1:0] cfg_data_i,
  output utf8d_pkg::cfg_t               cfg_o
);
  import utf8d_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        IDX_REJ_LO_MIN: cfg_d.rej_lo_min = cfg_data_i[ByteW-1:0];
        IDX_REJ_LO_MAX: cfg_d.rej_lo_max = cfg_data_i[ByteW-1:0];
        IDX_REJ_HI_MIN: cfg_d.rej_hi_min = cfg_data_i[ByteW-1:0];
        IDX_REJ_HI_MAX: cfg_d.rej_hi_max = cfg_data_i[ByteW-1:0];
        IDX_ERR_CP:     cfg_d.err_cp     = cfg_data_i[CpW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rej_lo_min <= RejLoMinRst;
      cfg_q.rej_lo_max <= RejLoMaxRst;
      cfg_q.rej_hi_min <= RejHiMinRst;
      cfg_q.rej_hi_max <= RejHiMaxRst;
      cfg_q.err_cp     <= ErrCpRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/utf8d_core.sv =====
// input register, single-pass sequence decode and result register
module utf8d_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  utf8d_pkg::cfg_t            cfg_i,
  input  logic                       in_vld_i,
  input  utf8d_pkg::window_t         win_i,
  input  logic [utf8d_pkg::LenW-1:0] avail_i,
  output logic                       done_o,
  output logic [utf8d_pkg::CpW-1:0]  codepoint_o,
  output logic [utf8d_pkg::LenW-1:0] consumed_o,
  output logic                       is_error_o
);
  import utf8d_pkg::*;

  // input stage
  logic            in_vld_q;
  window_t         win_q;
  logic [LenW-1:0] avail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_i) begin
      win_q   <= win_i;
      avail_q <= avail_i;
    end
  end

  // decode
  logic [ByteW-1:0] lead;
  logic [LenW-1:0]  trail;
  logic             in_lo, in_hi, short_seq, bad;
  logic [CpW-1:0]   acc;
  logic [CpW-1:0]   cp_d;
  logic [LenW-1:0]  cons_d;

  assign lead      = win_q[0];
  assign trail     = trail_count(lead);
  assign in_lo     = (lead >= cfg_i.rej_lo_min) && (lead <= cfg_i.rej_lo_max);
  assign in_hi     = (lead >= cfg_i.rej_hi_min) && (lead <= cfg_i.rej_hi_max);
  assign short_seq = (trail + 3'd1) > avail_q;
  assign bad       = in_lo || in_hi || short_seq;

  // low six bits of the shifted sum are zero, so only the top two bits of each byte overlap it
  always_comb begin
    acc = '0;
    for (int i = 0; i < NumBytes; i++) begin
      if (LenW'(i) <= trail) begin
        acc = {acc[CpW-7:0], 6'd0} + CpW'(win_q[i]);
      end
    end
  end

  always_comb begin
    if (bad) begin
      cp_d   = cfg_i.err_cp;
      cons_d = 3'd1;
    end else begin
      cp_d   = acc - len_offset(trail);
      cons_d = trail + 3'd1;
    end
  end

  // result stage
  logic            done_q;
  logic [CpW-1:0]  cp_q;
  logic [LenW-1:0] cons_q;
  logic            err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      cp_q   <= cp_d;
      cons_q <= cons_d;
      err_q  <= bad;
    end
  end

  assign done_o      = done_q;
  assign codepoint_o = cp_q;
  assign consumed_o  = cons_q;
  assign is_error_o  = err_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_i |-> ##2 done_o)
    else $error("accepted word did not produce a result two cycles later");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_vld_i, 2))
    else $error("result strobe without an accepted word");

  a_cons_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (consumed_o != 3'd0) && (consumed_o != 3'd7))
    else $error("consumed count out of range");

  a_err_cons: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_error_o) |-> (consumed_o == 3'd1) && (codepoint_o == cfg_i.err_cp))
    else $error("error result with wrong count or codepoint");
`endif

endmodule

// ===== rtl/core/utf8_sequence_decoder.sv =====
// top level of the utf-8 sequence decoder
//
// usage:
// - pulse start with a six-byte window on byte_0_i..byte_5_i (byte_0_i is the
//   leader) and the count of valid bytes on available_len_i; the word is taken
//   at every rising edge with start high and busy low
// - busy stays low: a new word can be taken every cycle, one result per word
// - each word is registered, decoded in one pass and registered again, so its
//   result comes from the result register, with done_o high for exactly
//   one cycle together with codepoint_o, consumed_o and is_error_o
// - throughput is one word per cycle; the input and result registers sit
//   around the decode logic
// - a rejected leader or a sequence longer than available_len_i gives the
//   error codepoint, consumed_o of 1 and is_error_o high
// - the receiver cannot stall: results are dropped if not sampled on done_o
// - configuration (cfg_we_i, cfg_idx_i, cfg_data_i) is written at any edge
//   with cfg_we_i high; the user must write it only while no word is in
//   flight, which the block does not enforce; indexes above four are ignored
// - reset clears the pipeline strobes and loads the default rejected ranges
//   80-C1 and F5-FF and error codepoint FFFD
module utf8_sequence_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cfg_we_i,
  input  logic [utf8d_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [utf8d_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [7:0]                     byte_0_i,
  input  logic [7:0]                     byte_1_i,
  input  logic [7:0]                     byte_2_i,
  input  logic [7:0]                     byte_3_i,
  input  logic [7:0]                     byte_4_i,
  input  logic [7:0]                     byte_5_i,
  input  logic [2:0]                     available_len_i,
  output logic                           done_o,
  output logic [31:0]                    codepoint_o,
  output logic [2:0]                     consumed_o,
  output logic                           is_error_o
);
  import utf8d_pkg::*;

  cfg_t    cfg;
  window_t win;

  assign busy = 1'b0;
  assign win  = {byte_5_i, byte_4_i, byte_3_i, byte_2_i, byte_1_i, byte_0_i};

  utf8d_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  utf8d_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_vld_i    (start && !busy),
    .win_i       (win),
    .avail_i     (available_len_i),
    .done_o      (done_o),
    .codepoint_o (codepoint_o),
    .consumed_o  (consumed_o),
    .is_error_o  (is_error_o)
  );

endmodule
